/* hdl/byte_difference_shift_xor_hash_core_assert.svh */
// Assertion macros shared by the checker of the hash core.
`ifndef BYTE_DIFFERENCE_SHIFT_XOR_HASH_CORE_ASSERT_SVH
`define BYTE_DIFFERENCE_SHIFT_XOR_HASH_CORE_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define BDSXH_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("hash core assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define BDSXH_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("hash core assertion failed");

`endif

/* hdl/bdsxh_pkg.sv */
// Package with the types, constants and helper functions of the hash core.
package bdsxh_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;

    localparam int    QUEUE_DEPTH_DEF = 4;
    localparam byte_t MAP_LOW_LIMIT   = 8'd32;
    localparam byte_t MAP_INVERT      = 8'd255;
    localparam word_t RESET_BUCKETS   = 32'd8209;

    // Item pushed from the front end into the queue.
    typedef struct packed {
        logic  valid;
        word_t acc;
    } hq_push_t;

    // Fill status of the queue.
    typedef struct packed {
        logic full;
        logic empty;
    } hq_status_t;

    function automatic byte_t remap_byte(input byte_t b);
        if (b < MAP_LOW_LIMIT)
        begin
            return MAP_INVERT - b;
        end
        return b - MAP_LOW_LIMIT;
    endfunction

    // A word modulo 255: 256 is congruent to 1, so the bytes are summed and folded.
    function automatic byte_t mod255(input word_t w);
        logic [9:0] sum;
        logic [8:0] fold;
        sum  = {2'b00, w[7:0]} + {2'b00, w[15:8]} + {2'b00, w[23:16]} + {2'b00, w[31:24]};
        fold = {1'b0, sum[7:0]} + {7'd0, sum[9:8]};
        if (fold >= 9'd255)
        begin
            fold = fold - 9'd255;
        end
        return fold[7:0];
    endfunction

endpackage

/* hdl/bdsxh_front.sv */
// Front end: accepts bytes, folds them into the accumulator and queues finished hashes.
module bdsxh_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  bdsxh_pkg::word_t       cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  bdsxh_pkg::byte_t       s_byte,
    input  bdsxh_pkg::hq_status_t  q_status,
    output bdsxh_pkg::hq_push_t    q_push,
    output bdsxh_pkg::word_t       modulus
);
    import bdsxh_pkg::*;

    word_t buckets_reg;
    byte_t seed_prev_reg;
    word_t acc_reg;
    word_t acc_next;
    byte_t prev_reg;
    byte_t prev_next;
    byte_t cur;
    byte_t diff;
    logic  accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign modulus = buckets_reg;

    assign q_push.valid = accept && (s_byte == 8'd0);
    assign q_push.acc   = acc_reg;

    always_comb
    begin
        cur  = remap_byte(s_byte);
        diff = (prev_reg < cur) ? (cur - prev_reg) : (prev_reg - cur);
        acc_next  = acc_reg;
        prev_next = prev_reg;
        if (accept)
        begin
            if (s_byte == 8'd0)
            begin
                acc_next  = buckets_reg - 32'd1;
                prev_next = seed_prev_reg;
            end
            else
            begin
                acc_next  = {acc_reg[28:0], 3'b000} ^ {24'd0, diff};
                prev_next = cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buckets_reg   <= RESET_BUCKETS;
            seed_prev_reg <= mod255(RESET_BUCKETS);
            acc_reg       <= RESET_BUCKETS - 32'd1;
            prev_reg      <= mod255(RESET_BUCKETS);
        end
        else if (cfg_we)
        begin
            // A register write abandons any string in progress and reseeds.
            buckets_reg   <= cfg_wdata;
            seed_prev_reg <= mod255(cfg_wdata);
            acc_reg       <= cfg_wdata - 32'd1;
            prev_reg      <= mod255(cfg_wdata);
        end
        else
        begin
            acc_reg  <= acc_next;
            prev_reg <= prev_next;
        end
    end

endmodule

/* hdl/bdsxh_queue.sv */
// Short queue of finished accumulator values between front end and back end.
module bdsxh_queue
#(
    parameter int DEPTH = bdsxh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdsxh_pkg::hq_push_t    push,
    input  logic                   pop,
    output bdsxh_pkg::word_t       head,
    output bdsxh_pkg::hq_status_t  status
);
    import bdsxh_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    word_t           mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push.acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hdl/bdsxh_back.sv */
// Back end: bit-serial restoring reduction of the accumulator and the output register.
module bdsxh_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bdsxh_pkg::hq_status_t  q_status,
    input  bdsxh_pkg::word_t       q_head,
    output logic                   q_pop,
    input  bdsxh_pkg::word_t       modulus,
    output logic                   m_valid,
    input  logic                   m_ready,
    output bdsxh_pkg::word_t       m_data
);
    import bdsxh_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg;
    logic [4:0]  cnt_reg;
    word_t       dvd_reg;
    word_t       rem_reg;
    word_t       rem_next;
    logic [32:0] trial;
    logic        out_valid_reg;
    word_t       out_data_reg;
    logic        load_out;

    assign q_pop    = (state_reg == ST_IDLE) && !q_status.empty;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // A zero modulus subtracts only zero, so the remainder ends as the raw accumulator.
    always_comb
    begin
        trial = {rem_reg, dvd_reg[31]};
        if (trial >= {1'b0, modulus})
        begin
            trial = trial - {1'b0, modulus};
        end
        rem_next = trial[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            dvd_reg <= q_head;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (load_out)
        begin
            out_data_reg <= rem_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* hdl/byte_difference_shift_xor_hash_core.sv */
// Path: a terminating zero byte pushes the accumulator into the queue; the idle back end pops it,
// reduces it in ST_DIV and loads the output register in ST_DONE, which raises m_axis_tvalid.
// Throughput: one byte per cycle; the back end reduces one hash at a time with a
// one-bit-per-cycle restoring divider, and the front end stalls only when the queue fills.
// Reset: asynchronous active low; bucket count returns to 8209, seeds reload, queue empties.
// Top level of the byte-difference shift-xor hash core.
module byte_difference_shift_xor_hash_core
#(
    parameter int QUEUE_DEPTH = bdsxh_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  bdsxh_pkg::word_t  cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] text_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata    // [31:0] bucket_index
);
    import bdsxh_pkg::*;

    hq_push_t   q_push;
    hq_status_t q_status;
    word_t      q_head;
    logic       q_pop;
    word_t      modulus;

    bdsxh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_byte    (s_axis_tdata),
        .q_status  (q_status),
        .q_push    (q_push),
        .modulus   (modulus)
    );

    bdsxh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    bdsxh_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .modulus  (modulus),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata)
    );

endmodule

/* hdl/bdsxh_checker.sv */
// Port-level checker of the hash core and its bind statement.
`include "byte_difference_shift_xor_hash_core_assert.svh"

module bdsxh_checker
#(
    parameter int QUEUE_DEPTH = bdsxh_pkg::QUEUE_DEPTH_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    // Terminators accepted whose results have not yet been taken.
    logic [7:0] pending_reg;
    logic       term_in;
    logic       res_out;

    assign term_in = s_axis_tvalid && s_axis_tready && (s_axis_tdata == 8'd0);
    assign res_out = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'd0, term_in} - {7'd0, res_out};
        end
    end

    `BDSXH_ASSERT_NEXT(a_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BDSXH_ASSERT_NEXT(a_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `BDSXH_ASSERT_NOW(a_no_invented, m_axis_tvalid, pending_reg != 8'd0)
    `BDSXH_ASSERT_NOW(a_stall_when_full, !s_axis_tready, pending_reg >= 8'(QUEUE_DEPTH))

endmodule

bind byte_difference_shift_xor_hash_core bdsxh_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the byte-difference shift-xor hash core.
module tb;
    import bdsxh_pkg::*;

    localparam int DRAIN_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    word_t             cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] text_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;   // [31:0] bucket_index

    // Shadow of the hashing state, advanced on every accepted item.
    word_t             shadow_buckets;
    word_t             shadow_acc;
    byte_t             shadow_prev;
    word_t             expected_buckets[$];
    int                mismatch_count = 0;
    bit                idling_on;
    int                sink_stall = 0;
    word_t             wanted_bucket;

    byte_difference_shift_xor_hash_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic byte_t remapped_code(input byte_t b);
        if (b < MAP_LOW_LIMIT)
        begin
            return MAP_INVERT - b;
        end
        return b - MAP_LOW_LIMIT;
    endfunction

    function void reseed_shadow();
        shadow_acc  = shadow_buckets - 32'd1;
        shadow_prev = byte_t'(shadow_buckets % 32'd255);
    endfunction

    // Advances the shadow hash by one accepted byte; a zero byte yields a bucket index.
    function void hash_byte(input byte_t b);
        byte_t cur;
        byte_t diff;
        if (b == 8'd0)
        begin
            if (shadow_buckets != 32'd0)
            begin
                expected_buckets.push_back(shadow_acc % shadow_buckets);
            end
            else
            begin
                expected_buckets.push_back(shadow_acc);
            end
            reseed_shadow();
        end
        else
        begin
            cur = remapped_code(b);
            diff = (shadow_prev > cur) ? shadow_prev - cur : cur - shadow_prev;
            shadow_prev = cur;
            shadow_acc = (shadow_acc << 3) ^ {24'd0, diff};
        end
    endfunction

    // The sink stalls in random bursts while idling is on.
    always @(posedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            sink_stall <= $urandom_range(0, 17);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_buckets.size() == 0)
            begin
                $display("%0t: unexpected bucket index, expected none, actual %0d",
                         $realtime, m_axis_tdata);
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                wanted_bucket = expected_buckets.pop_front();
                if (m_axis_tdata !== wanted_bucket)
                begin
                    $display("%0t: bucket_index mismatch, expected %0d, actual %0d",
                             $realtime, wanted_bucket, m_axis_tdata);
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    task automatic send_byte(input byte_t b);
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        hash_byte(b);
    endtask

    task automatic send_text(input byte_t text[$]);
        foreach (text[i])
        begin
            send_byte(text[i]);
        end
    endtask

    // Holds the sender back until every bucket index that is owed has come.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_buckets.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_bucket_count(input word_t value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_buckets = value;
        reseed_shadow();
    endtask

    // A random string of nonzero bytes, biased towards the remapping boundaries.
    task automatic send_random_string(input int max_len, input bit terminate);
        int len;
        byte_t b;
        len = $urandom_range(0, max_len);
        repeat (len)
        begin
            case ($urandom_range(0, 9))
                0:       b = 8'd31;
                1:       b = 8'd32;
                2:       b = 8'd255;
                3:       b = 8'd1;
                default: b = byte_t'($urandom_range(1, 255));
            endcase
            send_byte(b);
        end
        if (terminate)
        begin
            send_byte(8'd0);
        end
    endtask

    task automatic test_reset_seeds();
        // Empty strings, the remapping boundaries and a long run of equal bytes.
        send_text('{8'd0, 8'd0});
        send_text('{8'd1, 8'd31, 8'd32, 8'd33, 8'd255, 8'd128, 8'd127, 8'd0});
        send_text('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                    8'd255, 8'd255, 8'd255, 8'd0});
        // This string is abandoned by the register write that follows.
        send_text('{8'd65, 8'd66});
    endtask

    task automatic test_modulus_extremes();
        set_bucket_count(32'd1);
        send_text('{8'd0, 8'd200, 8'd3, 8'd0});
        set_bucket_count(32'hFFFF_FFFF);
        send_text('{8'd0, 8'd16, 8'd240, 8'd85, 8'd170, 8'd0});
        set_bucket_count(32'd255);
        send_text('{8'd0, 8'd100, 8'd0});
    endtask

    task automatic test_random_strings();
        word_t count;
        int sent;
        for (int phase = 0; phase < 5; phase++)
        begin
            if (phase % 2 == 0)
            begin
                count = $urandom_range(1, 300);
            end
            else
            begin
                count = $urandom();
                if (count == 32'd0)
                begin
                    count = 32'd1;
                end
            end
            set_bucket_count(count);
            for (sent = 0; sent < 130; sent += 8)
            begin
                send_random_string(14, 1'b1);
                if (phase == 2 && sent == 64)
                begin
                    wait_drained();
                end
            end
            // Leave a string unfinished so that the next write abandons it.
            send_random_string(6, 1'b0);
        end
    endtask

    task automatic test_back_to_back();
        idling_on = 1'b0;
        set_bucket_count(32'd8209);
        repeat (14)
        begin
            send_random_string(12, 1'b1);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        idling_on      = 1'b1;
        shadow_buckets = RESET_BUCKETS;
        reseed_shadow();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_seeds();
        test_modulus_extremes();
        test_random_strings();
        test_back_to_back();

        wait_drained();
        if (mismatch_count == 0 && expected_buckets.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
